>>> src/hcp_pkg.sv
// Shared types, constants and helpers for the Huffman code packer.
// Used by hcp_burst_queue, huffman_code_packer and hcp_checker; no dependencies.
`timescale 1ns / 1ps

package hcp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int SYM_W        = 8;
    localparam int MAX_CODE_LEN = 32;
    localparam int LEN_W        = 6;
    localparam int VAL_W        = 32;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + MAX_CODE_LEN;
    localparam int BURST_W      = 32;
    localparam int NBYTE_W      = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ENCODE = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SYM_W-1:0] symbol;
        logic [LEN_W-1:0] code_length;
        logic [VAL_W-1:0] code_value;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] pad_count;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0] code_length;
        logic [VAL_W-1:0] code_value;
    } entry_t;

    typedef struct packed {
        logic [BURST_W-1:0] data;
        logic [NBYTE_W-1:0] nbytes;
        logic               byte_valid;
        logic [2:0]         pad_count;
    } burst_t;

    function automatic logic [VAL_W-1:0] code_mask(input logic [LEN_W-1:0] len);
        logic [VAL_W:0] wide;
        begin
            wide = ({{VAL_W{1'b0}}, 1'b1} << len) - {{VAL_W{1'b0}}, 1'b1};
            code_mask = (len >= LEN_W'(VAL_W)) ? {VAL_W{1'b1}} : wide[VAL_W-1:0];
        end
    endfunction

endpackage

>>> src/hcp_burst_queue.sv
// Result queue: up to four bursts of packed bytes, sent one byte a cycle while res_stall is low.
// Depends on hcp_pkg for the burst and result types.
`timescale 1ns / 1ps

module hcp_burst_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  hcp_pkg::burst_t               push_data,
    output logic [hcp_pkg::QCNT_W-1:0]    level,
    output hcp_pkg::res_t                 res,
    output logic                          res_valid,
    input  logic                          res_stall
);

    hcp_pkg::burst_t                 q_mem [hcp_pkg::QUEUE_DEPTH];
    logic [hcp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [hcp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [hcp_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic [1:0]                      sent_reg, sent_next;
    hcp_pkg::burst_t                 head;
    logic [hcp_pkg::NBYTE_W-1:0]     byte_idx;
    logic                            head_last;
    logic                            take;
    logic                            pop;

    assign head      = q_mem[rd_ptr_reg];
    assign res_valid = (count_reg != '0);
    assign level     = count_reg;
    assign byte_idx  = head.nbytes - 3'd1 - {1'b0, sent_reg};
    assign head_last = ({1'b0, sent_reg} == (head.nbytes - 3'd1));
    assign take      = res_valid && !res_stall;
    assign pop       = take && head_last;

    always_comb
    begin
        res.out_byte   = head.data[{byte_idx[1:0], 3'b000} +: 8];
        res.byte_valid = head.byte_valid;
        res.pad_count  = head.pad_count;
        res.last       = head_last;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + hcp_pkg::QCNT_W'(push) - hcp_pkg::QCNT_W'(pop);
        if (pop)
        begin
            sent_next = 2'd0;
        end
        else if (take)
        begin
            sent_next = sent_reg + 2'd1;
        end
        else
        begin
            sent_next = sent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sent_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sent_reg   <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/huffman_code_packer.sv
// Top level of the Huffman code packer: code table memory, bit accumulator, result queue.
// Depends on hcp_pkg and hcp_burst_queue.
`timescale 1ns / 1ps

// Usage
//   Request channel (req, req_valid, req_stall): one request per cycle while
//   req_stall is low. A load writes one code table entry, an encode looks up
//   its symbol's code and appends it to the bit accumulator, a flush pads and
//   emits the partial byte, or an empty report if no bits are pending.
//   Result channel (res, res_valid, res_stall): one packed byte per cycle while
//   res_stall is low, earliest bit in the MSB; last marks the final byte of a request.
//   A request is registered with its table read, then accumulated into the result
//   queue. Throughput: one request per cycle while the result side keeps up; an
//   encode's bytes leave the result port one at a time, so sustained request rate
//   is set by the output byte rate and the four-burst result queue.
//   Stall: req_stall rises when the result queue plus the request in the
//   accumulate stage reach four bursts; nothing is dropped while res_stall
//   holds the result port.
//   Reset: clears every table entry to an empty code (per-entry valid bits,
//   no clearing pass), empties the accumulator and the result queue.

module huffman_code_packer (
    input  logic              clk,
    input  logic              rst_n,
    input  hcp_pkg::req_t     req,
    input  logic              req_valid,
    output logic              req_stall,
    output hcp_pkg::res_t     res,
    output logic              res_valid,
    input  logic              res_stall
);

    hcp_pkg::entry_t                 code_mem [hcp_pkg::SYMBOL_COUNT];
    logic [hcp_pkg::SYMBOL_COUNT-1:0] code_valid_reg;

    logic                            s1_valid_reg;
    logic [1:0]                      s1_kind_reg;
    logic                            s1_hit_reg;
    hcp_pkg::entry_t                 rd_entry_reg;
    logic [hcp_pkg::PEND_W-1:0]      pend_bits_reg, pend_bits_next;
    logic [hcp_pkg::PCNT_W-1:0]      pend_count_reg, pend_count_next;

    logic                            accept;
    logic [hcp_pkg::LEN_W-1:0]       load_len;
    logic [hcp_pkg::VAL_W-1:0]       load_val;
    logic [hcp_pkg::LEN_W-1:0]       enc_len;
    logic [hcp_pkg::ACC_W-1:0]       acc;
    logic [hcp_pkg::ACC_W-1:0]       acc_shifted;
    logic [hcp_pkg::LEN_W-1:0]       total;
    logic [2:0]                      rem;
    logic [7:0]                      rem_mask;
    logic [2:0]                      flush_pad;
    logic [7:0]                      flush_byte;
    logic                            push;
    hcp_pkg::burst_t                 push_data;
    logic [hcp_pkg::QCNT_W-1:0]      q_level;
    logic [hcp_pkg::QCNT_W-1:0]      in_flight;

    assign in_flight = q_level + hcp_pkg::QCNT_W'(s1_valid_reg);
    assign req_stall = (in_flight >= hcp_pkg::QCNT_W'(hcp_pkg::QUEUE_DEPTH));
    assign accept    = req_valid && !req_stall;

    assign load_len = (req.code_length > hcp_pkg::LEN_W'(hcp_pkg::MAX_CODE_LEN))
                    ? hcp_pkg::LEN_W'(hcp_pkg::MAX_CODE_LEN) : req.code_length;
    assign load_val = req.code_value & hcp_pkg::code_mask(load_len);

    always_ff @(posedge clk)
    begin
        if (accept && req.kind == hcp_pkg::KIND_LOAD)
        begin
            code_mem[req.symbol] <= '{code_length: load_len, code_value: load_val};
        end
        if (accept && req.kind == hcp_pkg::KIND_ENCODE)
        begin
            rd_entry_reg <= code_mem[req.symbol];
            s1_hit_reg   <= code_valid_reg[req.symbol];
        end
        if (accept)
        begin
            s1_kind_reg <= req.kind;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_valid_reg <= '0;
            s1_valid_reg   <= 1'b0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
        end
        else
        begin
            if (accept && req.kind == hcp_pkg::KIND_LOAD)
            begin
                code_valid_reg[req.symbol] <= 1'b1;
            end
            s1_valid_reg   <= accept;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
        end
    end

    // accumulate stage
    always_comb
    begin
        enc_len     = s1_hit_reg ? rd_entry_reg.code_length : '0;
        acc         = (hcp_pkg::ACC_W'(pend_bits_reg) << enc_len)
                    | (s1_hit_reg ? hcp_pkg::ACC_W'(rd_entry_reg.code_value) : '0);
        total       = hcp_pkg::LEN_W'(pend_count_reg) + enc_len;
        rem         = total[2:0];
        rem_mask    = (8'h01 << rem) - 8'h01;
        acc_shifted = acc >> rem;
        flush_pad   = 3'(4'd8 - {1'b0, pend_count_reg});
        flush_byte  = 8'({1'b0, pend_bits_reg} << flush_pad);

        push            = 1'b0;
        push_data       = '0;
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;

        if (s1_valid_reg)
        begin
            case (s1_kind_reg)
                hcp_pkg::KIND_ENCODE:
                begin
                    push                 = (total[5:3] != 3'd0);
                    push_data.data       = acc_shifted[hcp_pkg::BURST_W-1:0];
                    push_data.nbytes     = total[5:3];
                    push_data.byte_valid = 1'b1;
                    push_data.pad_count  = 3'd0;
                    pend_bits_next       = acc[hcp_pkg::PEND_W-1:0]
                                         & rem_mask[hcp_pkg::PEND_W-1:0];
                    pend_count_next      = rem;
                end
                hcp_pkg::KIND_FLUSH:
                begin
                    push                 = 1'b1;
                    push_data.data       = hcp_pkg::BURST_W'(flush_byte);
                    push_data.nbytes     = 3'd1;
                    push_data.byte_valid = (pend_count_reg != '0);
                    push_data.pad_count  = (pend_count_reg != '0) ? flush_pad : 3'd0;
                    pend_bits_next       = '0;
                    pend_count_next      = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    hcp_burst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .level     (q_level),
        .res       (res),
        .res_valid (res_valid),
        .res_stall (res_stall)
    );

endmodule

>>> src/hcp_checker.sv
// Port-level checks for huffman_code_packer, bound to the top level.
// Depends on hcp_pkg for the request and result types.
`timescale 1ns / 1ps

module hcp_checker (
    input logic          clk,
    input logic          rst_n,
    input hcp_pkg::req_t req,
    input logic          req_valid,
    input logic          req_stall,
    input hcp_pkg::res_t res,
    input logic          res_valid,
    input logic          res_stall
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.byte_valid |->
            res.last && res.out_byte == 8'd0 && res.pad_count == 3'd0)
        else $error("empty flush report malformed");

    a_pad_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.pad_count != 3'd0 |-> res.last && res.byte_valid)
        else $error("padded byte not final or not valid");

    a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |-> res.byte_valid && res.pad_count == 3'd0)
        else $error("non-final result carries flush fields");

endmodule

bind huffman_code_packer hcp_checker u_hcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall)
);
